@@ sv/crc32fr_pkg.sv @@
`default_nettype none

package crc32fr_pkg;

    localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
    localparam logic [2:0]  CrcLenBytes = 3'd4;

    localparam logic [7:0]  SyncReset   = 8'h02;
    localparam logic [15:0] MaxLenReset = 16'd512;

    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] RegSyncByte     = 8'd0;
    localparam logic [CfgIndexWidth-1:0] RegMaxPayloadLen = 8'd1;

    localparam logic [2:0] EvHeader  = 3'd0;
    localparam logic [2:0] EvPayload = 3'd1;
    localparam logic [2:0] EvGood    = 3'd2;
    localparam logic [2:0] EvBadCrc  = 3'd3;
    localparam logic [2:0] EvTooLong = 3'd4;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/crc32_frame_receiver.sv @@
`default_nettype none

// Framed packet receiver: one received byte per beat, one beat a cycle. It hunts
// for sync_byte, then takes a command byte and a big-endian 16-bit length; a length
// above max_payload_len gives a "length too long" beat and the block hunts again.
// Otherwise it gives a header beat, then one beat per payload byte as it arrives,
// then reads a big-endian CRC-32 (IEEE, reflected, init and final xor all ones, over
// command, length and payload) and gives a good or bad-CRC verdict beat. The
// parser step and a byte-wide CRC update sit between the input port and a single
// output register, so a new byte is taken every cycle as long as that register is
// empty or being drained; in_stall rises only while a result is
// held there under out_stall. Registers may be written only while no frame is in
// progress; cfg_ready is always high.
module crc32_frame_receiver
    import crc32fr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               rx_data,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [2:0]                    event_kind,
    output logic [7:0]                    frame_command,
    output logic [15:0]                   frame_length,
    output logic [7:0]                    payload_byte,
    output logic [15:0]                   payload_index,
    output logic                          last_payload
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC     = 3'd5;

    logic [7:0]  sync_byte_reg;
    logic [15:0] max_len_reg;

    logic [2:0]  phase_reg,          phase_next;
    logic [7:0]  held_command_reg,   held_command_next;
    logic [15:0] held_length_reg,    held_length_next;
    logic [15:0] bytes_seen_reg,     bytes_seen_next;
    logic [31:0] running_crc_reg,    running_crc_next;
    logic [31:0] received_crc_reg,   received_crc_next;
    logic [2:0]  crc_bytes_seen_reg, crc_bytes_seen_next;

    logic        out_valid_reg;
    logic [2:0]  event_kind_reg,    event_kind_next;
    logic [7:0]  payload_byte_reg,  payload_byte_next;
    logic [15:0] payload_index_reg, payload_index_next;
    logic        last_payload_reg,  last_payload_next;
    logic [7:0]  frame_command_reg;
    logic [15:0] frame_length_reg;

    logic        in_accept;
    logic        emit;
    logic [31:0] crc_fed;
    logic [15:0] seen_inc;
    logic [15:0] len_full;
    logic [31:0] rx_crc_full;
    logic [2:0]  crc_cnt_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign crc_fed     = crc32_byte((phase_reg == PH_CMD) ? CrcInit : running_crc_reg, rx_data);
    assign seen_inc    = bytes_seen_reg + 16'd1;
    assign len_full    = {held_length_reg[15:8], rx_data};
    assign rx_crc_full = {received_crc_reg[23:0], rx_data};
    assign crc_cnt_inc = crc_bytes_seen_reg + 3'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        held_command_next   = held_command_reg;
        held_length_next    = held_length_reg;
        bytes_seen_next     = bytes_seen_reg;
        running_crc_next    = running_crc_reg;
        received_crc_next   = received_crc_reg;
        crc_bytes_seen_next = crc_bytes_seen_reg;
        emit                = 1'b0;
        event_kind_next     = EvHeader;
        payload_byte_next   = 8'd0;
        payload_index_next  = 16'd0;
        last_payload_next   = 1'b0;
        unique case (phase_reg)
            PH_CMD:
            begin
                held_command_next = rx_data;
                running_crc_next  = crc_fed;
                phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                held_length_next = {rx_data, 8'd0};
                running_crc_next = crc_fed;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                held_length_next    = len_full;
                running_crc_next    = crc_fed;
                bytes_seen_next     = 16'd0;
                crc_bytes_seen_next = 3'd0;
                received_crc_next   = 32'd0;
                emit                = 1'b1;
                if (len_full > max_len_reg)
                begin
                    phase_next      = PH_HUNT;
                    event_kind_next = EvTooLong;
                end
                else
                begin
                    phase_next      = (len_full != 16'd0) ? PH_PAYLOAD : PH_CRC;
                    event_kind_next = EvHeader;
                end
            end
            PH_PAYLOAD:
            begin
                running_crc_next   = crc_fed;
                bytes_seen_next    = seen_inc;
                emit               = 1'b1;
                event_kind_next    = EvPayload;
                payload_byte_next  = rx_data;
                payload_index_next = bytes_seen_reg;
                last_payload_next  = (seen_inc == held_length_reg);
                if (seen_inc == held_length_reg)
                begin
                    crc_bytes_seen_next = 3'd0;
                    received_crc_next   = 32'd0;
                    phase_next          = PH_CRC;
                end
            end
            PH_CRC:
            begin
                received_crc_next   = rx_crc_full;
                crc_bytes_seen_next = crc_cnt_inc;
                if (crc_cnt_inc >= CrcLenBytes)
                begin
                    phase_next      = PH_HUNT;
                    emit            = 1'b1;
                    event_kind_next = (rx_crc_full == ~running_crc_reg) ? EvGood : EvBadCrc;
                end
            end
            default:
            begin
                phase_next = (rx_data == sync_byte_reg) ? PH_CMD : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg      <= SyncReset;
            max_len_reg        <= MaxLenReset;
            phase_reg          <= PH_HUNT;
            held_command_reg   <= 8'd0;
            held_length_reg    <= 16'd0;
            bytes_seen_reg     <= 16'd0;
            running_crc_reg    <= CrcInit;
            received_crc_reg   <= 32'd0;
            crc_bytes_seen_reg <= 3'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegSyncByte)
                begin
                    sync_byte_reg <= cfg_data[7:0];
                end
                else if (cfg_index == RegMaxPayloadLen)
                begin
                    max_len_reg <= cfg_data;
                end
            end
            if (in_accept)
            begin
                phase_reg          <= phase_next;
                held_command_reg   <= held_command_next;
                held_length_reg    <= held_length_next;
                bytes_seen_reg     <= bytes_seen_next;
                running_crc_reg    <= running_crc_next;
                received_crc_reg   <= received_crc_next;
                crc_bytes_seen_reg <= crc_bytes_seen_next;
            end
            if (in_accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // load the result beat; the register is free whenever a byte is accepted
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            event_kind_reg    <= event_kind_next;
            frame_command_reg <= held_command_next;
            frame_length_reg  <= held_length_next;
            payload_byte_reg  <= payload_byte_next;
            payload_index_reg <= payload_index_next;
            last_payload_reg  <= last_payload_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = event_kind_reg;
    assign frame_command = frame_command_reg;
    assign frame_length  = frame_length_reg;
    assign payload_byte  = payload_byte_reg;
    assign payload_index = payload_index_reg;
    assign last_payload  = last_payload_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty output register");

    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> (held_length_reg != 16'd0) &&
                                    (bytes_seen_reg < held_length_reg))
        else $error("payload count outside the announced length");

    a_crc_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CRC |-> crc_bytes_seen_reg < CrcLenBytes)
        else $error("CRC byte count overran");

    a_too_long_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && phase_reg == PH_LEN_LO && len_full > max_len_reg
        |=> phase_reg == PH_HUNT && out_valid_reg && event_kind_reg == EvTooLong)
        else $error("oversize frame not reported and dropped");

    a_last_ends_payload: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && phase_reg == PH_PAYLOAD && seen_inc == held_length_reg
        |=> phase_reg == PH_CRC && last_payload_reg)
        else $error("final payload byte did not advance to the CRC");

endmodule

`default_nettype wire
